// File: design/dwc_pkg.sv
// shared constants, types and helpers for the depthwise 3x3 convolution block
package dwc_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_CHANNELS = 64;
    localparam int MAX_HEIGHT   = 1024;
    localparam int TAPS         = 9;
    localparam int MAX_STRIDE   = 8;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int CH_W    = $clog2(MAX_CHANNELS);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int MOD_W   = $clog2(MAX_STRIDE);
    localparam int LINE_AW = COL_W + CH_W;
    localparam int CW_W    = 48;
    localparam int PROD_W  = 16;
    localparam int SUM_W   = 20;
    localparam int ACC_W   = 34;

    // input word function codes
    localparam logic [1:0] FUNC_WEIGHT = 2'd0;
    localparam logic [1:0] FUNC_BIAS   = 2'd1;
    localparam logic [1:0] FUNC_PIXEL  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_CHANS  = 2'd2;
    localparam logic [1:0] CFG_STRIDE = 2'd3;

    typedef struct packed {
        logic [10:0] height;
        logic [8:0]  width;
        logic [6:0]  chans;
        logic [3:0]  stride;
    } cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] col;
        logic [CH_W-1:0]  ch;
        logic [ROW_W-1:0] oh;
        logic [COL_W-1:0] ow;
        logic             emit;
        logic             last;
    } pos_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [CH_W-1:0]  chan;
        logic             last;
    } meta_t;

    typedef struct packed {
        logic signed [7:0] value;
        meta_t             meta;
    } res_t;

    function automatic logic [10:0] sat_height(input logic [10:0] v);
        logic [10:0] r;
        if (v < 11'd3)
            r = 11'd3;
        else if (v > 11'(MAX_HEIGHT))
            r = 11'(MAX_HEIGHT);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [8:0] sat_width(input logic [8:0] v);
        logic [8:0] r;
        if (v < 9'd3)
            r = 9'd3;
        else if (v > 9'(MAX_WIDTH))
            r = 9'(MAX_WIDTH);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [6:0] sat_chans(input logic [6:0] v);
        logic [6:0] r;
        if (v < 7'd1)
            r = 7'd1;
        else if (v > 7'(MAX_CHANNELS))
            r = 7'(MAX_CHANNELS);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [3:0] sat_stride(input logic [3:0] v);
        logic [3:0] r;
        if (v < 4'd1)
            r = 4'd1;
        else if (v > 4'(MAX_STRIDE))
            r = 4'(MAX_STRIDE);
        else
            r = v;
        return r;
    endfunction

endpackage

// File: design/dwc_if.sv
// valid/ready channel interfaces for input words and result words
interface dwc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [5:0]        channel_index;
    logic [3:0]        tap_index;
    logic signed [7:0] sample_or_weight;
    logic signed [31:0] bias_value;

    modport source (output valid, func, channel_index, tap_index, sample_or_weight,
                    bias_value, input ready);
    modport sink (input valid, func, channel_index, tap_index, sample_or_weight,
                  bias_value, output ready);
endinterface

interface dwc_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] output_value;
    logic [9:0]        out_row;
    logic [7:0]        out_col;
    logic [5:0]        out_channel;
    logic              last_of_frame;

    modport source (output valid, output_value, out_row, out_col, out_channel,
                    last_of_frame, input ready);
    modport sink (input valid, output_value, out_row, out_col, out_channel,
                  last_of_frame, output ready);
endinterface

// File: design/dwc_ram.sv
// generic single write, single read ram with registered read
module dwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/dwc_seq.sv
// raster position counters and stride grid tracking
module dwc_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          restart,
    input  logic          step,
    input  dwc_pkg::cfg_t cfg,
    output dwc_pkg::pos_t pos
);

    logic [dwc_pkg::ROW_W-1:0] r_reg, r_next, oh_reg, oh_next;
    logic [dwc_pkg::COL_W-1:0] col_reg, col_next, ow_reg, ow_next;
    logic [dwc_pkg::CH_W-1:0]  ch_reg, ch_next;
    logic [dwc_pkg::MOD_W-1:0] rmod_reg, rmod_next, cmod_reg, cmod_next;
    logic                      ch_wrap, col_wrap, row_wrap, rmod_wrap, cmod_wrap;

    // wrap conditions
    assign ch_wrap   = ({1'b0, ch_reg} + 7'd1) == cfg.chans;
    assign col_wrap  = ({1'b0, col_reg} + 9'd1) == cfg.width;
    assign row_wrap  = ({1'b0, r_reg} + 11'd1) == cfg.height;
    assign rmod_wrap = ({1'b0, rmod_reg} + 4'd1) == cfg.stride;
    assign cmod_wrap = ({1'b0, cmod_reg} + 4'd1) == cfg.stride;

    // current position
    always_comb
    begin
        pos.r    = r_reg;
        pos.col  = col_reg;
        pos.ch   = ch_reg;
        pos.oh   = oh_reg;
        pos.ow   = ow_reg;
        pos.emit = (r_reg >= 10'd2) && (col_reg >= 8'd2) && (rmod_reg == '0)
                   && (cmod_reg == '0);
        pos.last = pos.emit && ch_wrap
                   && (({1'b0, r_reg} + {7'd0, cfg.stride}) >= cfg.height)
                   && (({1'b0, col_reg} + {5'd0, cfg.stride}) >= cfg.width);
    end

    // next position
    always_comb
    begin
        r_next    = r_reg;
        col_next  = col_reg;
        ch_next   = ch_reg;
        oh_next   = oh_reg;
        ow_next   = ow_reg;
        rmod_next = rmod_reg;
        cmod_next = cmod_reg;
        if (restart)
        begin
            r_next    = '0;
            col_next  = '0;
            ch_next   = '0;
            oh_next   = '0;
            ow_next   = '0;
            rmod_next = '0;
            cmod_next = '0;
        end
        else if (step)
        begin
            if (!ch_wrap)
                ch_next = ch_reg + 6'd1;
            else
            begin
                ch_next = '0;
                if (!col_wrap)
                begin
                    col_next = col_reg + 8'd1;
                    if (col_reg >= 8'd2)
                    begin
                        cmod_next = cmod_wrap ? '0 : cmod_reg + 3'd1;
                        ow_next   = cmod_wrap ? ow_reg + 8'd1 : ow_reg;
                    end
                    else
                    begin
                        cmod_next = '0;
                        ow_next   = '0;
                    end
                end
                else
                begin
                    col_next  = '0;
                    cmod_next = '0;
                    ow_next   = '0;
                    if (row_wrap)
                    begin
                        r_next    = '0;
                        rmod_next = '0;
                        oh_next   = '0;
                    end
                    else
                    begin
                        r_next = r_reg + 10'd1;
                        if (r_reg >= 10'd2)
                        begin
                            rmod_next = rmod_wrap ? '0 : rmod_reg + 3'd1;
                            oh_next   = rmod_wrap ? oh_reg + 10'd1 : oh_reg;
                        end
                        else
                        begin
                            rmod_next = '0;
                            oh_next   = '0;
                        end
                    end
                end
            end
        end
    end

    // counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg    <= '0;
            col_reg  <= '0;
            ch_reg   <= '0;
            oh_reg   <= '0;
            ow_reg   <= '0;
            rmod_reg <= '0;
            cmod_reg <= '0;
        end
        else
        begin
            r_reg    <= r_next;
            col_reg  <= col_next;
            ch_reg   <= ch_next;
            oh_reg   <= oh_next;
            ow_reg   <= ow_next;
            rmod_reg <= rmod_next;
            cmod_reg <= cmod_next;
        end
    end

endmodule

// File: design/dwc_mac.sv
// nine-tap multiply, sum, bias add and clamp pipeline
module dwc_mac (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [71:0]    win,
    input  logic [71:0]    wts,
    input  logic [31:0]    bias,
    input  dwc_pkg::meta_t meta,
    output logic           out_valid,
    output dwc_pkg::res_t  res
);

    logic signed [dwc_pkg::PROD_W-1:0] prod_reg [dwc_pkg::TAPS];
    logic signed [31:0]                bias2_reg, bias3_reg;
    dwc_pkg::meta_t                    meta2_reg, meta3_reg, meta4_reg;
    logic                              v2_reg, v3_reg, v4_reg;
    logic signed [dwc_pkg::SUM_W-1:0]  sum_next, sum_reg;
    logic signed [dwc_pkg::ACC_W-1:0]  acc;
    logic signed [7:0]                 val_next, val_reg;

    // products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < dwc_pkg::TAPS; k++)
                prod_reg[k] <= $signed(win[8*k +: 8]) * $signed(wts[8*k +: 8]);
            bias2_reg <= $signed(bias);
            meta2_reg <= meta;
        end
    end

    // product sum
    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < dwc_pkg::TAPS; k++)
            sum_next = sum_next + dwc_pkg::SUM_W'(prod_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg   <= sum_next;
            bias3_reg <= bias2_reg;
            meta3_reg <= meta2_reg;
        end
    end

    // bias add and clamp
    always_comb
    begin
        acc = dwc_pkg::ACC_W'(bias3_reg) + dwc_pkg::ACC_W'(sum_reg);
        if (acc > 34'sd127)
            val_next = 8'sd127;
        else if (acc < -34'sd128)
            val_next = -8'sd128;
        else
            val_next = acc[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg   <= val_next;
            meta4_reg <= meta3_reg;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign res.value  = val_reg;
    assign res.meta   = meta4_reg;

endmodule

// File: design/dwc_ofifo.sv
// two-word output queue that decouples the pipeline from the receiver
module dwc_ofifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dwc_pkg::res_t wdata,
    output logic          room,
    dwc_out_if.source     res_out
);

    dwc_pkg::res_t mem_reg [2];
    logic          wptr_reg, rptr_reg;
    logic [1:0]    count_reg, count_next;
    logic          pop;

    assign pop  = res_out.valid && res_out.ready;
    assign room = count_reg != 2'd2;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wdata;
    end

    // pointers and fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            count_reg <= count_next;
        end
    end

    // output word
    assign res_out.valid         = count_reg != 2'd0;
    assign res_out.output_value  = mem_reg[rptr_reg].value;
    assign res_out.out_row       = mem_reg[rptr_reg].meta.row;
    assign res_out.out_col       = mem_reg[rptr_reg].meta.col;
    assign res_out.out_channel   = mem_reg[rptr_reg].meta.chan;
    assign res_out.last_of_frame = mem_reg[rptr_reg].meta.last;

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) push |-> (count_reg != 2'd2) || pop;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("output queue overflow");

endmodule

// File: design/depthwise_conv3x3_int8.sv
// top level of the streaming depthwise 3x3 int8 convolution
//
// pix_in carries one word per accepted valid/ready handshake: a weight load, a bias
// load or a pixel sample (raster order, channel innermost). Weights and biases
// must be loaded before the pixels that use them. res_out carries one word for
// each pixel that completes a 3x3 window on the stride grid, in row, column,
// channel order, with last_of_frame set on the final word of a frame.
// The cfg port writes height, width, channel count and stride (saturated to
// their legal ranges); any write restarts the frame. Write only while idle.
// Throughput: one input word per clock while the output queue has room. A result
// word passes the ram read, multiply, product sum, bias add and clamp registers
// and the output queue. The column window ram is read and written back for
// each pixel; back-to-back pixels of the same channel are forwarded.
// Reset clears the counters, the pipeline and the output queue; the line,
// window, weight and bias rams keep no reset contents and need no clearing.
// When the receiver stalls, a two-word output queue absorbs results; once it is
// full the whole pipeline holds and pix_in.ready drops until a word is taken.
module depthwise_conv3x3_int8 (
    input  logic       clk,
    input  logic       rst_n,
    dwc_in_if.sink     pix_in,
    dwc_out_if.source  res_out,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [10:0] cfg_data
);

    dwc_pkg::cfg_t cfg_reg;
    dwc_pkg::pos_t pos;
    logic          en, acc_in, acc_pix, room;

    // stage one registers
    logic                      p1_valid_reg, p1_emit_reg, p1_slot_reg;
    logic [dwc_pkg::CH_W-1:0]  p1_ch_reg;
    logic [7:0]                p1_sample_reg;
    dwc_pkg::meta_t            p1_meta_reg;

    // window forwarding
    logic                      fwd_valid_reg;
    logic [dwc_pkg::CH_W-1:0]  fwd_ch_reg;
    logic [dwc_pkg::CW_W-1:0]  fwd_data_reg;

    logic [dwc_pkg::LINE_AW-1:0] line_addr;
    logic [7:0]                  line0_q, line1_q, old_px, mid_px;
    logic [dwc_pkg::CW_W-1:0]    cw_q, cw_cur, cw_new;
    logic [71:0]                 win, wts;
    logic [31:0]                 bias_q;
    logic                        mac_valid;
    dwc_pkg::res_t               mac_res;

    assign en      = room;
    assign acc_in  = pix_in.valid && en;
    assign acc_pix = acc_in && (pix_in.func == dwc_pkg::FUNC_PIXEL);
    assign pix_in.ready = en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.height <= 11'd3;
            cfg_reg.width  <= 9'd3;
            cfg_reg.chans  <= 7'd1;
            cfg_reg.stride <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dwc_pkg::CFG_HEIGHT: cfg_reg.height <= dwc_pkg::sat_height(cfg_data);
                dwc_pkg::CFG_WIDTH:  cfg_reg.width  <= dwc_pkg::sat_width(cfg_data[8:0]);
                dwc_pkg::CFG_CHANS:  cfg_reg.chans  <= dwc_pkg::sat_chans(cfg_data[6:0]);
                dwc_pkg::CFG_STRIDE: cfg_reg.stride <= dwc_pkg::sat_stride(cfg_data[3:0]);
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // position counters
    dwc_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_we),
        .step    (acc_pix),
        .cfg     (cfg_reg),
        .pos     (pos)
    );

    assign line_addr = {pos.col, pos.ch};

    // line rows, one ram per row parity
    dwc_ram #(.WIDTH(8), .DEPTH(dwc_pkg::MAX_WIDTH * dwc_pkg::MAX_CHANNELS)) u_line0 (
        .clk   (clk),
        .we    (acc_pix && !pos.r[0]),
        .waddr (line_addr),
        .wdata (pix_in.sample_or_weight),
        .re    (en),
        .raddr (line_addr),
        .rdata (line0_q)
    );

    dwc_ram #(.WIDTH(8), .DEPTH(dwc_pkg::MAX_WIDTH * dwc_pkg::MAX_CHANNELS)) u_line1 (
        .clk   (clk),
        .we    (acc_pix && pos.r[0]),
        .waddr (line_addr),
        .wdata (pix_in.sample_or_weight),
        .re    (en),
        .raddr (line_addr),
        .rdata (line1_q)
    );

    // per-tap weight rams
    for (genvar t = 0; t < dwc_pkg::TAPS; t++)
    begin : g_wt
        dwc_ram #(.WIDTH(8), .DEPTH(dwc_pkg::MAX_CHANNELS)) u_wt (
            .clk   (clk),
            .we    (acc_in && (pix_in.func == dwc_pkg::FUNC_WEIGHT)
                    && (pix_in.tap_index == 4'(t))),
            .waddr (pix_in.channel_index),
            .wdata (pix_in.sample_or_weight),
            .re    (en),
            .raddr (pos.ch),
            .rdata (wts[8*t +: 8])
        );
    end

    // bias ram
    dwc_ram #(.WIDTH(32), .DEPTH(dwc_pkg::MAX_CHANNELS)) u_bias (
        .clk   (clk),
        .we    (acc_in && (pix_in.func == dwc_pkg::FUNC_BIAS)),
        .waddr (pix_in.channel_index),
        .wdata (pix_in.bias_value),
        .re    (en),
        .raddr (pos.ch),
        .rdata (bias_q)
    );

    // column window ram, read at accept, written back from stage one
    dwc_ram #(.WIDTH(dwc_pkg::CW_W), .DEPTH(dwc_pkg::MAX_CHANNELS)) u_cwin (
        .clk   (clk),
        .we    (en && p1_valid_reg),
        .waddr (p1_ch_reg),
        .wdata (cw_new),
        .re    (en),
        .raddr (pos.ch),
        .rdata (cw_q)
    );

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p1_emit_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg  <= acc_pix;
            p1_emit_reg   <= acc_pix && pos.emit;
            fwd_valid_reg <= p1_valid_reg;
        end
    end

    // stage one payload and forwarding data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_ch_reg        <= pos.ch;
            p1_slot_reg      <= pos.r[0];
            p1_sample_reg    <= pix_in.sample_or_weight;
            p1_meta_reg.row  <= pos.oh;
            p1_meta_reg.col  <= pos.ow;
            p1_meta_reg.chan <= pos.ch;
            p1_meta_reg.last <= pos.last;
            fwd_ch_reg       <= p1_ch_reg;
            fwd_data_reg     <= cw_new;
        end
    end

    // window assembly
    always_comb
    begin
        cw_cur = (fwd_valid_reg && (fwd_ch_reg == p1_ch_reg)) ? fwd_data_reg : cw_q;
        old_px = p1_slot_reg ? line1_q : line0_q;
        mid_px = p1_slot_reg ? line0_q : line1_q;
        // taps row-major: left column from bytes 0..2, middle from 3..5
        for (int i = 0; i < 3; i++)
        begin
            win[8*(3*i) +: 8]     = cw_cur[8*i +: 8];
            win[8*(3*i + 1) +: 8] = cw_cur[8*(3 + i) +: 8];
        end
        win[8*2 +: 8] = old_px;
        win[8*5 +: 8] = mid_px;
        win[8*8 +: 8] = p1_sample_reg;
        cw_new = {p1_sample_reg, mid_px, old_px, cw_cur[8*3 +: 24]};
    end

    dwc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p1_emit_reg),
        .win       (win),
        .wts       (wts),
        .bias      (bias_q),
        .meta      (p1_meta_reg),
        .out_valid (mac_valid),
        .res       (mac_res)
    );

    dwc_ofifo u_ofifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (en && mac_valid),
        .wdata   (mac_res),
        .room    (room),
        .res_out (res_out)
    );

    property p_hold_on_stall;
        @(posedge clk) disable iff (!rst_n)
            !en |=> $stable(p1_valid_reg) && $stable(p1_emit_reg);
    endproperty
    a_hold_on_stall: assert property (p_hold_on_stall) else $error("stage one moved while stalled");

    property p_emit_is_pixel;
        @(posedge clk) disable iff (!rst_n) p1_emit_reg |-> p1_valid_reg;
    endproperty
    a_emit_is_pixel: assert property (p_emit_is_pixel) else $error("emit without pixel");

    property p_emit_follows;
        @(posedge clk) disable iff (!rst_n) (acc_pix && pos.emit) |=> p1_emit_reg;
    endproperty
    a_emit_follows: assert property (p_emit_follows) else $error("window result dropped");

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the depthwise 3x3 int8 convolution block
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         func;
        logic [5:0]         chan;
        logic [3:0]         tap;
        logic signed [7:0]  sw;
        logic signed [31:0] bias;
    } in_word_t;

    localparam int SETTLE_CYCLES = 10;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int LOADED_CHANS  = 4;
    localparam int WORD_BUDGET   = 950;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [10:0] cfg_data;

    dwc_in_if  pix ();
    dwc_out_if res ();

    depthwise_conv3x3_int8 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix),
        .res_out  (res),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow copy of the block state
    logic [10:0] height_reg;
    logic [8:0]  width_reg;
    logic [6:0]  chans_reg;
    logic [3:0]  stride_reg;
    logic signed [7:0]  line_mem [2][dwc_pkg::MAX_WIDTH][dwc_pkg::MAX_CHANNELS];
    logic signed [7:0]  col_win [dwc_pkg::MAX_CHANNELS][6];
    logic signed [7:0]  kernel [dwc_pkg::TAPS][dwc_pkg::MAX_CHANNELS];
    logic signed [31:0] chan_bias [dwc_pkg::MAX_CHANNELS];
    int row_pos, col_pos, chan_pos;

    dwc_pkg::res_t conv_expected [$];
    int errors = 0;
    int words_sent = 0;
    int results_seen = 0;
    int frames_done = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    int stall_mode = 0;
    int stall_cnt = 0;
    int quiet_cycles = 0;

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int eff_height();
        return clip(int'(height_reg), 3, dwc_pkg::MAX_HEIGHT);
    endfunction

    function automatic int eff_width();
        return clip(int'(width_reg), 3, dwc_pkg::MAX_WIDTH);
    endfunction

    function automatic int eff_chans();
        return clip(int'(chans_reg), 1, dwc_pkg::MAX_CHANNELS);
    endfunction

    function automatic int eff_stride();
        return clip(int'(stride_reg), 1, dwc_pkg::MAX_STRIDE);
    endfunction

    // slide the window for one sample and queue the convolution it completes
    function automatic void conv_pixel(logic signed [7:0] sample);
        int h, w, c, s, r, col, ch, old_s, mid_s;
        logic signed [7:0] win [3][3];
        longint acc;
        dwc_pkg::res_t e;
        h = eff_height();
        w = eff_width();
        c = eff_chans();
        s = eff_stride();
        r = row_pos;
        col = col_pos;
        ch = chan_pos;
        if (r >= h || col >= w || ch >= c)
        begin
            r = 0;
            col = 0;
            ch = 0;
        end
        old_s = r & 1;
        mid_s = (r + 1) & 1;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = col_win[ch][k];
            win[k][1] = col_win[ch][3 + k];
        end
        win[0][2] = line_mem[old_s][col][ch];
        win[1][2] = line_mem[mid_s][col][ch];
        win[2][2] = sample;
        line_mem[old_s][col][ch] = sample;
        for (int k = 0; k < 3; k++)
        begin
            col_win[ch][k] = win[k][1];
            col_win[ch][3 + k] = win[k][2];
        end
        if (r >= 2 && col >= 2 && (r - 2) % s == 0 && (col - 2) % s == 0)
        begin
            acc = longint'(chan_bias[ch]);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    acc += longint'(win[i][j]) * longint'(kernel[i * 3 + j][ch]);
            if (acc > 127)
                acc = 127;
            if (acc < -128)
                acc = -128;
            e.value = 8'(acc);
            e.meta.row = dwc_pkg::ROW_W'((r - 2) / s);
            e.meta.col = dwc_pkg::COL_W'((col - 2) / s);
            e.meta.chan = dwc_pkg::CH_W'(ch);
            e.meta.last = ((r - 2) / s == (h - 3) / s) && ((col - 2) / s == (w - 3) / s)
                          && (ch == c - 1);
            conv_expected.push_back(e);
            if (e.meta.last)
                frames_done++;
        end
        ch++;
        if (ch >= c)
        begin
            ch = 0;
            col++;
            if (col >= w)
            begin
                col = 0;
                r++;
                if (r >= h)
                    r = 0;
            end
        end
        row_pos = r;
        col_pos = col;
        chan_pos = ch;
    endfunction

    function automatic void apply_word(in_word_t wd);
        case (wd.func)
            dwc_pkg::FUNC_WEIGHT:
                if (wd.tap < dwc_pkg::TAPS)
                    kernel[wd.tap][wd.chan] = wd.sw;
            dwc_pkg::FUNC_BIAS:
                chan_bias[wd.chan] = wd.bias;
            dwc_pkg::FUNC_PIXEL:
                conv_pixel(wd.sw);
            default:
                ;
        endcase
    endfunction

    // one input word, with bursts and gaps on the sender side
    task automatic send_word(in_word_t wd);
        if (gaps_on && burst_left <= 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        pix.valid <= 1'b1;
        pix.func <= wd.func;
        pix.channel_index <= wd.chan;
        pix.tap_index <= wd.tap;
        pix.sample_or_weight <= wd.sw;
        pix.bias_value <= wd.bias;
        do
            @(posedge clk);
        while (!pix.ready);
        apply_word(wd);
        words_sent++;
    endtask

    task automatic send_pixel(logic signed [7:0] v);
        in_word_t wd;
        wd.func = dwc_pkg::FUNC_PIXEL;
        wd.chan = 6'($urandom);
        wd.tap = 4'($urandom);
        wd.sw = v;
        wd.bias = $urandom;
        send_word(wd);
    endtask

    task automatic send_weight(int ch, int tap, logic signed [7:0] v);
        in_word_t wd;
        wd.func = dwc_pkg::FUNC_WEIGHT;
        wd.chan = 6'(ch);
        wd.tap = 4'(tap);
        wd.sw = v;
        wd.bias = $urandom;
        send_word(wd);
    endtask

    task automatic send_bias(int ch, logic signed [31:0] b);
        in_word_t wd;
        wd.func = dwc_pkg::FUNC_BIAS;
        wd.chan = 6'(ch);
        wd.tap = 4'($urandom);
        wd.sw = 8'($urandom);
        wd.bias = b;
        send_word(wd);
    endtask

    // unknown function code or weight load with an out-of-range tap
    task automatic send_junk();
        in_word_t wd;
        wd.func = ($urandom_range(0, 1) != 0) ? 2'd3 : dwc_pkg::FUNC_WEIGHT;
        wd.chan = 6'($urandom);
        wd.tap = 4'($urandom_range(dwc_pkg::TAPS, 15));
        wd.sw = 8'($urandom);
        wd.bias = $urandom;
        send_word(wd);
    endtask

    task automatic load_channel(int ch, logic signed [7:0] wv, logic signed [31:0] b);
        for (int t = 0; t < dwc_pkg::TAPS; t++)
            send_weight(ch, t, wv);
        send_bias(ch, b);
    endtask

    // sender pause until every expected word is back, then settle
    task automatic drain();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (conv_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(int h, int w, int c, int s);
        int vals [4];
        logic [1:0] idx [4];
        vals = '{h, w, c, s};
        idx = '{dwc_pkg::CFG_HEIGHT, dwc_pkg::CFG_WIDTH, dwc_pkg::CFG_CHANS,
                dwc_pkg::CFG_STRIDE};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= 11'(vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        height_reg = 11'(h);
        width_reg = 9'(w);
        chans_reg = 7'(c);
        stride_reg = 4'(s);
        row_pos = 0;
        col_pos = 0;
        chan_pos = 0;
    endtask

    function automatic logic signed [7:0] pick_sample(int kind);
        case (kind)
            1: return 8'sd127;
            2: return -8'sd128;
            3: return 8'($urandom_range(0, 15) - 8);
            default: return 8'($urandom);
        endcase
    endfunction

    // a run of samples that may stop partway through a frame
    task automatic send_pixels(int n, int kind);
        for (int i = 0; i < n; i++)
            send_pixel(pick_sample(kind));
    endtask

    // whole frames of samples, with optional loads and junk mixed in
    task automatic run_frames(int nframes, int kind, int noise_pct);
        int n;
        n = eff_height() * eff_width() * eff_chans() * nframes;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                case ($urandom_range(0, 2))
                    0: send_weight($urandom_range(0, 63), $urandom_range(0, 8),
                                   8'($urandom));
                    1: send_bias($urandom_range(0, 63), $urandom_range(0, 600) - 300);
                    default: send_junk();
                endcase
            end
            send_pixel(pick_sample(kind));
        end
    endtask

    task automatic test_load_all();
        for (int ch = 0; ch < LOADED_CHANS; ch++)
        begin
            for (int t = 0; t < dwc_pkg::TAPS; t++)
                send_weight(ch, t, 8'($urandom));
            send_bias(ch, $urandom_range(0, 400) - 200);
        end
    endtask

    // saturation at both ends from weights, samples and bias
    task automatic test_clamp();
        write_cfg(3, 3, 1, 1);
        load_channel(0, 8'sd127, 0);
        run_frames(1, 1, 0);
        load_channel(0, -8'sd128, 0);
        run_frames(1, 1, 0);
        run_frames(1, 2, 0);
        load_channel(0, 8'sd0, 32'sh7fffffff);
        run_frames(1, 0, 0);
        load_channel(0, -8'sd128, 32'sh80000000);
        run_frames(1, 2, 0);
        load_channel(0, 8'sd1, -5);
        run_frames(1, 3, 0);
    endtask

    // junk words and mid-frame loads among pixels
    task automatic test_ignored_words();
        write_cfg(4, 4, 2, 1);
        for (int i = 0; i < 2; i++)
            load_channel(i, 8'($urandom_range(0, 6) - 3), $urandom_range(0, 40) - 20);
        for (int i = 0; i < 32; i++)
        begin
            send_junk();
            send_pixel(pick_sample(3));
        end
        run_frames(1, 3, 30);
    endtask

    // out-of-range and boundary register values, large shapes cut short
    task automatic test_cfg_extremes();
        write_cfg(0, 0, 0, 0);
        run_frames(2, 3, 0);
        write_cfg(2047, 511, 127, 15);
        send_pixels(40, 3);
        write_cfg(1024, 3, 1, 8);
        send_pixels(33, 3);
        write_cfg(9, 10, 2, 8);
        run_frames(1, 3, 0);
        write_cfg(4, 5, 3, 3);
        send_pixels(17, 0);
    endtask

    // random geometry, mostly whole frames, some cut short
    task automatic test_random();
        while (words_sent < WORD_BUDGET)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_mode = $urandom_range(0, 3);
            write_cfg($urandom_range(3, 5), $urandom_range(3, 6), $urandom_range(1, 3),
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
            if ($urandom_range(0, 4) != 0)
                run_frames(1, $urandom_range(0, 3), 4);
            else
                send_pixels($urandom_range(1, 40), 0);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        dwc_pkg::res_t e;
        if (rst_n && res.valid && res.ready)
        begin
            results_seen++;
            if (conv_expected.size() == 0)
                report_mismatch("unexpected word", 32'(res.output_value), 32'd0);
            else
            begin
                e = conv_expected.pop_front();
                if (res.output_value !== e.value)
                    report_mismatch("output_value", 32'(res.output_value), 32'(e.value));
                if (res.out_row !== e.meta.row)
                    report_mismatch("out_row", 32'(res.out_row), 32'(e.meta.row));
                if (res.out_col !== e.meta.col)
                    report_mismatch("out_col", 32'(res.out_col), 32'(e.meta.col));
                if (res.out_channel !== e.meta.chan)
                    report_mismatch("out_channel", 32'(res.out_channel), 32'(e.meta.chan));
                if (res.last_of_frame !== e.meta.last)
                    report_mismatch("last_of_frame", 32'(res.last_of_frame),
                                    32'(e.meta.last));
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        stall_cnt++;
        case (stall_mode)
            1: res.ready <= ($urandom_range(0, 3) != 0);
            2: res.ready <= (stall_cnt % 11 < 7);
            3: res.ready <= ($urandom_range(0, 1) != 0);
            default: res.ready <= 1'b1;
        endcase
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_MAX)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        pix.valid <= 1'b0;
        pix.func <= dwc_pkg::FUNC_PIXEL;
        pix.channel_index <= '0;
        pix.tap_index <= '0;
        pix.sample_or_weight <= '0;
        pix.bias_value <= '0;
        cfg_we <= 1'b0;
        cfg_index <= dwc_pkg::CFG_HEIGHT;
        cfg_data <= '0;
        height_reg = 11'd3;
        width_reg = 9'd3;
        chans_reg = 7'd1;
        stride_reg = 4'd1;
        row_pos = 0;
        col_pos = 0;
        chan_pos = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on = 1'b0;
        test_load_all();
        test_clamp();
        gaps_on = 1'b1;
        stall_mode = 1;
        test_ignored_words();
        stall_mode = 2;
        test_cfg_extremes();
        test_random();
        drain();

        $display("covered %0d input words, %0d result words, %0d complete frames",
                 words_sent, results_seen, frames_done);
        $display("register extremes, clamping, junk words, mid-frame loads, strides 1-8");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
